/* sv/stack_with_delete_by_value_assert.svh */
// Assertion macros for the stack with delete-by-value checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef STACK_WITH_DELETE_BY_VALUE_ASSERT_SVH
`define STACK_WITH_DELETE_BY_VALUE_ASSERT_SVH

// Clocked assertion, switched off while reset is held
`define SWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define SWD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/swd_pkg.sv */
// Shared types and constants for the stack with delete-by-value.
// Used by swd_ram users, swd_ctrl, the top level and the checker; no dependencies.
package swd_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2
  } swd_op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } swd_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_TOP_RD,
    S_TOP_LD,
    S_DONE
  } swd_state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } swd_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] taken_value;
    logic               top_valid;
    logic signed [31:0] top_value;
    logic [4:0]         entries_used;
  } swd_out_t;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic       in_fire;
    logic [1:0] func;
    logic       cnt_zero;
    logic       cnt_one;
    logic       pend;
    logic       match;
    logic       cmp_zero;
    logic       shift_more;
    logic       out_free;
  } swd_flags_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic scan_issue;
    logic scan_hit;
    logic scan_miss;
    logic shift_wr;
    logic shift_issue;
    logic shift_end;
    logic top_rd;
    logic top_ld;
    logic out_load;
  } swd_ctrl_t;

endpackage

/* sv/swd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module swd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/swd_ctrl.sv */
// Sequencer for the stack: steps the scan, shift and top-reload phases.
// Depends on swd_pkg for the state enum and the flag and command structs.
module swd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  swd_pkg::swd_flags_t flags,
  output swd_pkg::swd_ctrl_t  ctrl
);

  swd_pkg::swd_state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swd_pkg::S_IDLE: begin
        if (flags.in_fire) begin
          case (flags.func)
            swd_pkg::OP_POP: begin
              state_nxt = (flags.cnt_zero || flags.cnt_one) ? swd_pkg::S_DONE
                                                            : swd_pkg::S_TOP_RD;
            end
            swd_pkg::OP_DELETE: begin
              state_nxt = flags.cnt_zero ? swd_pkg::S_DONE : swd_pkg::S_SCAN;
            end
            default: begin
              state_nxt = swd_pkg::S_DONE;
            end
          endcase
        end
      end
      swd_pkg::S_SCAN: begin
        if (flags.pend && flags.match) begin
          state_nxt = swd_pkg::S_SHIFT;
        end else if (flags.pend && flags.cmp_zero) begin
          state_nxt = swd_pkg::S_DONE;
        end
      end
      swd_pkg::S_SHIFT: begin
        if (!flags.shift_more) begin
          state_nxt = flags.cnt_one ? swd_pkg::S_DONE : swd_pkg::S_TOP_RD;
        end
      end
      swd_pkg::S_TOP_RD: begin
        state_nxt = swd_pkg::S_TOP_LD;
      end
      swd_pkg::S_TOP_LD: begin
        state_nxt = swd_pkg::S_DONE;
      end
      swd_pkg::S_DONE: begin
        if (flags.out_free) begin
          state_nxt = swd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swd_pkg::S_IDLE;
      end
    endcase
  end

  // Commands for the datapath
  always_comb begin
    ctrl = '0;
    case (state_r)
      swd_pkg::S_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.accept   = flags.in_fire;
      end
      swd_pkg::S_SCAN: begin
        ctrl.scan_hit   = flags.pend && flags.match;
        ctrl.scan_miss  = flags.pend && !flags.match && flags.cmp_zero;
        ctrl.scan_issue = !(flags.pend && (flags.match || flags.cmp_zero));
      end
      swd_pkg::S_SHIFT: begin
        ctrl.shift_wr    = flags.pend;
        ctrl.shift_issue = flags.shift_more;
        ctrl.shift_end   = !flags.shift_more;
      end
      swd_pkg::S_TOP_RD: begin
        ctrl.top_rd = 1'b1;
      end
      swd_pkg::S_TOP_LD: begin
        ctrl.top_ld = 1'b1;
      end
      swd_pkg::S_DONE: begin
        ctrl.out_load = flags.out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

/* sv/stack_with_delete_by_value.sv */
// Bounded stack with push, pop and delete-by-value; one request in flight at a time.
// Push, unused, and pop or delete on an empty stack go from idle straight to the result stage;
// a pop that leaves entries first reloads the top. Delete scans down from the top, and on a hit
// closes the gap and reloads the top if entries remain; the next request is taken as the result appears.
// A result held by out_ready keeps in_ready low. Synchronous active-low reset empties the
// stack; entry storage itself is not cleared. Depends on swd_pkg, swd_ram and swd_ctrl.
module stack_with_delete_by_value (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swd_pkg::swd_in_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output swd_pkg::swd_out_t out_rsp
);

  localparam int AW = swd_pkg::ADDR_W;
  localparam int CW = swd_pkg::CNT_W;

  swd_pkg::swd_flags_t flags;
  swd_pkg::swd_ctrl_t  ctrl;

  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   top_r, top_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   taken_r, taken_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] cmp_r, cmp_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r;
  swd_pkg::swd_out_t out_rsp_r, rsp_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] k_dec;
  logic          cnt_full;

  swd_ram #(
    .WIDTH(swd_pkg::DATA_W),
    .DEPTH(swd_pkg::STACK_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  swd_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .flags(flags),
    .ctrl (ctrl)
  );

  assign cnt_dec  = count_r - CW'(1);
  assign k_dec    = k_r - CW'(1);
  assign cnt_full = (count_r >= CW'(swd_pkg::STACK_DEPTH));

  // Gather conditions for the sequencer; ready is high only in idle, so valid alone fires there
  always_comb begin
    flags.in_fire    = in_valid;
    flags.func       = in_req.func;
    flags.cnt_zero   = (count_r == '0);
    flags.cnt_one    = (count_r == CW'(1));
    flags.pend       = pend_r;
    flags.match      = (rdata == key_r);
    flags.cmp_zero   = (cmp_r == '0);
    flags.shift_more = (k_r < count_r);
    flags.out_free   = !out_valid_r || out_ready;
  end

  // Datapath: request decode, top-down search, gap close, top reload
  always_comb begin
    count_nxt  = count_r;
    top_nxt    = top_r;
    status_nxt = status_r;
    taken_nxt  = taken_r;
    key_nxt    = key_r;
    ptr_nxt    = ptr_r;
    cmp_nxt    = cmp_r;
    k_nxt      = k_r;
    pend_nxt   = pend_r;
    we         = 1'b0;
    waddr      = cmp_r;
    wdata      = rdata;
    raddr      = ptr_r;

    if (ctrl.accept) begin
      status_nxt = swd_pkg::ST_DONE;
      taken_nxt  = '0;
      case (in_req.func)
        swd_pkg::OP_PUSH: begin
          if (cnt_full) begin
            status_nxt = swd_pkg::ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = count_r[AW-1:0];
            wdata     = in_req.value;
            count_nxt = count_r + CW'(1);
            top_nxt   = in_req.value;
          end
        end
        swd_pkg::OP_POP: begin
          if (flags.cnt_zero) begin
            status_nxt = swd_pkg::ST_EMPTY;
          end else begin
            count_nxt = cnt_dec;
            taken_nxt = top_r;
          end
        end
        swd_pkg::OP_DELETE: begin
          if (flags.cnt_zero) begin
            status_nxt = swd_pkg::ST_EMPTY;
          end else begin
            key_nxt  = in_req.value;
            ptr_nxt  = cnt_dec[AW-1:0];
            pend_nxt = 1'b0;
          end
        end
        default: begin
          status_nxt = swd_pkg::ST_DONE;
        end
      endcase
    end

    // Search: read one entry a cycle, compare the one read last cycle
    if (ctrl.scan_issue) begin
      raddr    = ptr_r;
      cmp_nxt  = ptr_r;
      pend_nxt = 1'b1;
      ptr_nxt  = ptr_r - AW'(1);
    end
    if (ctrl.scan_hit) begin
      taken_nxt = key_r;
      k_nxt     = CW'(cmp_r) + CW'(1);
      pend_nxt  = 1'b0;
    end
    if (ctrl.scan_miss) begin
      status_nxt = swd_pkg::ST_MISSING;
    end

    // Close the gap: write back the entry read last cycle one place lower
    if (ctrl.shift_wr) begin
      we    = 1'b1;
      waddr = cmp_r;
      wdata = rdata;
    end
    if (ctrl.shift_issue) begin
      raddr    = k_r[AW-1:0];
      cmp_nxt  = k_dec[AW-1:0];
      pend_nxt = 1'b1;
      k_nxt    = k_r + CW'(1);
    end
    if (ctrl.shift_end) begin
      pend_nxt  = 1'b0;
      count_nxt = cnt_dec;
    end

    // Reload the top entry
    if (ctrl.top_rd) begin
      raddr = cnt_dec[AW-1:0];
    end
    if (ctrl.top_ld) begin
      top_nxt = rdata;
    end
  end

  // Hold datapath state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    top_r    <= top_nxt;
    status_r <= status_nxt;
    taken_r  <= taken_nxt;
    key_r    <= key_nxt;
    ptr_r    <= ptr_nxt;
    cmp_r    <= cmp_nxt;
    k_r      <= k_nxt;
  end

  // Build the result
  always_comb begin
    rsp_nxt.status       = status_r;
    rsp_nxt.taken_value  = taken_r;
    rsp_nxt.top_valid    = !flags.cnt_zero;
    rsp_nxt.top_value    = flags.cnt_zero ? '0 : top_r;
    rsp_nxt.entries_used = 5'(count_r);
  end

  // Output register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.out_load) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign in_ready  = ctrl.in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

/* sv/swd_checker.sv */
// Port-level checker for the stack with delete-by-value, bound to the top level.
// Depends on swd_pkg and the assertion macros in stack_with_delete_by_value_assert.svh.
`include "stack_with_delete_by_value_assert.svh"

module swd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input swd_pkg::swd_in_t  in_req,
  input logic              out_valid,
  input logic              out_ready,
  input swd_pkg::swd_out_t out_rsp
);

  // A stalled result holds
  `SWD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rsp), "result changed while stalled")

  // One request at a time: ready drops after each accepted request
  `SWD_ASSERT(a_one_req, in_valid && in_ready |=> !in_ready, "request accepted while busy")

  // An empty stack shows no top value and no entries
  `SWD_ASSERT(a_empty_view, out_valid && !out_rsp.top_valid |-> out_rsp.top_value == 0 && out_rsp.entries_used == 0, "empty stack shows data")

  // Failed requests take nothing
  `SWD_ASSERT(a_fail_zero, out_valid && out_rsp.status != swd_pkg::ST_DONE |-> out_rsp.taken_value == 0, "failed request returned a value")

endmodule

bind stack_with_delete_by_value swd_checker u_swd_checker (.*);

/* sim/stack_with_delete_by_value_tb.sv */
// Self-checking bench for stack_with_delete_by_value: push, pop and delete-by-value requests
// are checked against a shadow stack, with random idling on both channels.
// Depends on swd_pkg and the stack_with_delete_by_value RTL.
module stack_with_delete_by_value_tb;
  import swd_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         TAIL_CYCLES = 2 * STACK_DEPTH + 8;
  localparam int         PHASE_REQS  = 170;
  localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX    = 32'h7fff_ffff;

  typedef struct {
    swd_in_t req;
    int      tx_idle;
    int      rx_idle;
    bit      wait_drain;
    bit      hold_rx;
  } queued_req_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  swd_in_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  swd_out_t out_rsp;

  queued_req_t queued_reqs[$];
  swd_out_t    due_results[$];

  // Shadow copy of the stack contents
  logic [31:0] shadow_stack [STACK_DEPTH];
  int          shadow_count = 0;

  int  reqs_accepted   = 0;
  int  results_checked = 0;
  int  fail_count      = 0;
  int  cycle_count     = 0;
  int  rx_idle_now     = 0;
  int  rx_hold_left    = 0;
  logic rx_hold_kick   = 1'b0;

  // Request generation settings
  int          gen_tx_idle;
  int          gen_rx_idle;
  bit          gen_wait_drain;
  bit          gen_hold_rx;
  logic [31:0] key_pool [6];

  stack_with_delete_by_value dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Apply one request to the shadow stack and return the result it should give
  function automatic swd_out_t stack_op_result(swd_in_t r);
    swd_out_t res;
    int       hit_at;
    res        = '0;
    res.status = ST_DONE;
    case (r.func)
      OP_PUSH: begin
        if (shadow_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_stack[shadow_count] = r.value;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_count--;
          res.taken_value = shadow_stack[shadow_count];
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit_at = -1;
          for (int p = shadow_count - 1; p >= 0; p--) begin
            if (shadow_stack[p] == r.value) begin
              hit_at = p;
              break;
            end
          end
          if (hit_at < 0) begin
            res.status = ST_MISSING;
          end else begin
            res.taken_value = r.value;
            for (int k = hit_at; k + 1 < shadow_count; k++) begin
              shadow_stack[k] = shadow_stack[k + 1];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    if (shadow_count > 0) begin
      res.top_valid = 1'b1;
      res.top_value = shadow_stack[shadow_count - 1];
    end
    res.entries_used = 5'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("result %0d: %s: got %08h, want %08h", results_checked, what, got, want);
    end
  endtask

  task automatic add_req(logic [1:0] func, logic [31:0] value);
    queued_req_t q;
    q.req.func   = func;
    q.req.value  = value;
    q.tx_idle    = gen_tx_idle;
    q.rx_idle    = gen_rx_idle;
    q.wait_drain = gen_wait_drain;
    q.hold_rx    = gen_hold_rx;
    queued_reqs.push_back(q);
    gen_wait_drain = 1'b0;
    gen_hold_rx    = 1'b0;
  endtask

  // Mostly keys from a small pool so that deletes find duplicates and hits
  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) < 8) begin
      return key_pool[$urandom_range(5)];
    end
    return $urandom;
  endfunction

  task automatic refill_pool();
    logic [31:0] extremes [4];
    extremes = '{VAL_MIN, VAL_MAX, 32'h0, 32'hffff_ffff};
    foreach (key_pool[i]) begin
      key_pool[i] = ($urandom_range(3) == 0) ? extremes[$urandom_range(3)] : $urandom;
    end
  endtask

  // Offer queued requests; predict each one as it is accepted
  always @(posedge clk) begin : drive_requests
    bit          fire;
    bit          present;
    bit          kick;
    bit          drained;
    queued_req_t nxt;
    fire    = in_valid && in_ready;
    present = in_valid && !fire;
    kick    = 1'b0;
    if (!rst_n) begin
      present = 1'b0;
    end else begin
      if (fire) begin
        due_results.push_back(stack_op_result(in_req));
      end
      if ((!in_valid || fire) && queued_reqs.size() > 0) begin
        nxt     = queued_reqs[0];
        drained = !fire && (reqs_accepted == results_checked);
        if ((!nxt.wait_drain || drained) && $urandom_range(99) >= nxt.tx_idle) begin
          queued_reqs.delete(0);
          in_req      <= nxt.req;
          rx_idle_now <= nxt.rx_idle;
          present     = 1'b1;
          kick        = nxt.hold_rx;
        end
      end
    end
    reqs_accepted <= reqs_accepted + (fire ? 1 : 0);
    in_valid      <= present;
    rx_hold_kick  <= kick;
  end

  // Take results, compare against the oldest expectation, and pace out_ready
  always @(posedge clk) begin : check_results
    swd_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_checked >= reqs_accepted) begin
          report_mismatch("result with no request", out_rsp.taken_value, 32'h0);
        end else begin
          want = due_results.pop_front();
          if (out_rsp.status !== want.status)
            report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
          if (out_rsp.taken_value !== want.taken_value)
            report_mismatch("taken_value", out_rsp.taken_value, want.taken_value);
          if (out_rsp.top_valid !== want.top_valid)
            report_mismatch("top_valid", 32'(out_rsp.top_valid), 32'(want.top_valid));
          if (out_rsp.top_value !== want.top_value)
            report_mismatch("top_value", out_rsp.top_value, want.top_value);
          if (out_rsp.entries_used !== want.entries_used)
            report_mismatch("entries_used", 32'(out_rsp.entries_used),
                            32'(want.entries_used));
          results_checked <= results_checked + 1;
        end
      end
      // Hold off for a long stretch when the driver asks
      if (rx_hold_kick) begin
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_now);
      end
    end
  end

  // Build the request list, release reset, and wait for the stack to drain
  initial begin : stimulus
    int  made;
    int  n;
    int  pick;
    bit  hold_set;
    bit  pause_set;
    gen_tx_idle    = 25;
    gen_rx_idle    = 65;
    gen_wait_drain = 1'b0;
    gen_hold_rx    = 1'b0;
    refill_pool();

    // Directed: empty stack, extremes, duplicates, gap closing, unused code
    add_req(OP_POP, 32'h0);
    add_req(OP_DELETE, 32'h0);
    add_req(OP_UNUSED, 32'hffff_ffff);
    add_req(OP_PUSH, VAL_MIN);
    add_req(OP_PUSH, VAL_MAX);
    add_req(OP_PUSH, 32'h0);
    add_req(OP_PUSH, 32'hffff_ffff);
    add_req(OP_PUSH, VAL_MAX);
    add_req(OP_DELETE, 32'h5);
    add_req(OP_DELETE, VAL_MAX);
    add_req(OP_POP, 32'hffff_ffff);
    add_req(OP_UNUSED, VAL_MIN);
    add_req(OP_DELETE, VAL_MIN);
    add_req(OP_POP, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_POP, 32'h0);
    add_req(OP_DELETE, VAL_MAX);

    // Random: three idling phases of burst-shaped traffic
    for (int ph = 0; ph < 3; ph++) begin
      gen_tx_idle    = (ph == 0) ? 25 : (ph == 1) ? 65 : 0;
      gen_rx_idle    = (ph == 0) ? 65 : (ph == 1) ? 25 : 0;
      gen_wait_drain = 1'b1;
      made      = 0;
      hold_set  = 1'b0;
      pause_set = 1'b0;
      while (made < PHASE_REQS) begin
        if (ph != 1 && made >= 60 && !hold_set) begin
          gen_hold_rx = 1'b1;
          hold_set    = 1'b1;
        end
        if (made >= 110 && !pause_set) begin
          gen_wait_drain = 1'b1;
          pause_set      = 1'b1;
        end
        if ($urandom_range(3) == 0) begin
          refill_pool();
        end
        pick = $urandom_range(9);
        if (pick <= 2) begin
          // fill towards and past full
          n = $urandom_range(4, STACK_DEPTH + 4);
          repeat (n) add_req(OP_PUSH, pick_key());
        end else if (pick <= 4) begin
          n = $urandom_range(2, 10);
          repeat (n) add_req(OP_DELETE, pick_key());
        end else if (pick == 5) begin
          n = $urandom_range(2, STACK_DEPTH + 2);
          repeat (n) add_req(OP_POP, $urandom);
        end else if (pick == 6) begin
          // noise: any code, any value
          n = 5;
          repeat (n) add_req(2'($urandom_range(3)), $urandom);
        end else begin
          n = 10;
          repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 40)      add_req(OP_PUSH, pick_key());
            else if (pick < 60) add_req(OP_POP, pick_key());
            else if (pick < 95) add_req(OP_DELETE, pick_key());
            else                add_req(OP_UNUSED, $urandom);
          end
        end
        made += n;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_reqs.size() != 0 || in_valid || results_checked != reqs_accepted) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      report_mismatch("results never returned", 32'(due_results.size()), 32'h0);
    end
    if (fail_count == 0) begin
      $display("stack_with_delete_by_value: match");
    end else begin
      $display("stack_with_delete_by_value: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("stack_with_delete_by_value: mismatch");
    $finish;
  end

endmodule
